@@ rtl/core/bmrw_pkg.sv @@
// Package for the block map range walker: map geometry constants, field widths,
// codes for operations, result kinds and walk levels, and the pointer read helpers.
// Depends on nothing; every file of the walker imports it.
package bmrw_pkg;

    // Map geometry.
    localparam int SECTOR_BYTES      = 512;
    localparam int DIRECT_ENTRIES    = 123;
    localparam int ENTRIES_PER_BLOCK = 128;
    localparam int WORD_BYTES        = 4;
    localparam int DIRECT_BASE       = 8;
    localparam int INDIRECT_SLOT     = 12;
    localparam int DOUBLY_SLOT       = 8;

    localparam int SECTOR_LOG2 = $clog2(SECTOR_BYTES);
    localparam int EPB_LOG2    = $clog2(ENTRIES_PER_BLOCK);
    localparam int WORD_LOG2   = $clog2(WORD_BYTES);

    // Field widths.
    localparam int SEC_W   = 32;
    localparam int OFS_W   = 24;
    localparam int SOFS_W  = 9;
    localparam int LEN_W   = 10;
    localparam int IDX_W   = 15;
    localparam int CHUNK_W = SECTOR_LOG2 + 1;

    // First sector indexes served by the indirect block and by the doubly indirect block.
    localparam logic [IDX_W-1:0] DIRECT_IDX = IDX_W'(DIRECT_ENTRIES);
    localparam logic [IDX_W-1:0] BEYOND_IDX = IDX_W'(DIRECT_ENTRIES + ENTRIES_PER_BLOCK);

    typedef enum logic {
        OP_REQUEST  = 1'b0,
        OP_RESPONSE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_PTR_READ = 2'd0,
        KIND_CHUNK    = 2'd1,
        KIND_EMPTY    = 2'd2
    } result_kind_t;

    // Meaning of the pointer word that the walk waits for.
    typedef enum logic [1:0] {
        LVL_NONE = 2'd0,
        LVL_DATA = 2'd1,
        LVL_IND  = 2'd2,
        LVL_DBL  = 2'd3
    } level_t;

    typedef struct packed {
        result_kind_t      kind;
        logic [SEC_W-1:0]  sector;
        logic [SOFS_W-1:0] sofs;
        logic [LEN_W-1:0]  len;
        logic [OFS_W-1:0]  done;
        logic              last;
    } result_t;

    // Byte offset of entry j of a pointer block, cut to the sector offset width.
    function automatic logic [SOFS_W-1:0] entry_offset(input logic [IDX_W-1:0] j);
        return SOFS_W'(j << WORD_LOG2);
    endfunction

    // Level of the first pointer word needed for a sector index.
    function automatic level_t level_of(input logic [IDX_W-1:0] idx);
        level_t lvl;
        if (idx < DIRECT_IDX) begin
            lvl = LVL_DATA;
        end else if (idx < BEYOND_IDX) begin
            lvl = LVL_IND;
        end else begin
            lvl = LVL_DBL;
        end
        return lvl;
    endfunction

    // First pointer read of the chunk at a sector index, taken from the inode sector.
    function automatic result_t begin_read(input logic [SEC_W-1:0] home,
                                           input logic [IDX_W-1:0] idx);
        result_t r;
        r        = '0;
        r.kind   = KIND_PTR_READ;
        r.sector = home;
        if (idx < DIRECT_IDX) begin
            r.sofs = SOFS_W'(DIRECT_BASE) + entry_offset(idx);
        end else if (idx < BEYOND_IDX) begin
            r.sofs = SOFS_W'(SECTOR_BYTES - INDIRECT_SLOT);
        end else begin
            r.sofs = SOFS_W'(SECTOR_BYTES - DOUBLY_SLOT);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/block_map_range_walker_core.sv @@
// Block map range walker: splits a byte range into per-sector chunks and walks
// the direct, indirect and doubly indirect map for each. Imports bmrw_pkg.
//
// Results are registered into a result queue and offered on the m_ channel in
// order. Throughput: one input transaction per cycle while s_ready is high, set by
// the single registered update of the walk state; a transaction that yields two
// results takes two transfers of the output port. Synchronous active-low reset
// empties the result queue and leaves the walker idle.
module block_map_range_walker_core
    import bmrw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [SEC_W-1:0]  s_inode_sector,
    input  logic [OFS_W-1:0]  s_start_offset,
    input  logic [OFS_W-1:0]  s_byte_count,
    input  logic [OFS_W-1:0]  s_file_length,
    input  logic [SEC_W-1:0]  s_read_word,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_result_kind,
    output logic [SEC_W-1:0]  m_sector_number,
    output logic [SOFS_W-1:0] m_sector_offset,
    output logic [LEN_W-1:0]  m_chunk_length,
    output logic [OFS_W-1:0]  m_bytes_done,
    output logic              m_last
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Walk state.
    logic               active_reg, active_next;
    level_t             level_reg, level_next;
    logic [SEC_W-1:0]   home_reg, home_next;
    logic [OFS_W-1:0]   cursor_reg, cursor_next;
    logic [OFS_W-1:0]   count_reg, count_next;
    logic [OFS_W-1:0]   file_left_reg, file_left_next;
    logic [OFS_W-1:0]   done_reg, done_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;

    // Result queue.
    result_t            queue_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  qcount_reg;

    logic               in_accept, out_accept;
    logic [1:0]         push_cnt;
    result_t            res0, res1;

    // Request side: first chunk and sector index straight from the ports.
    logic [OFS_W-1:0]   req_file_left, req_min;
    logic [CHUNK_W-1:0] req_sec_left, req_chunk;
    logic [IDX_W-1:0]   req_idx;

    // Data side: remaining amounts after the current chunk and the next chunk.
    logic [OFS_W-1:0]   cnt_after, fl_after, min_after;
    logic [CHUNK_W-1:0] next_chunk;
    logic [IDX_W-1:0]   idx_inc, dbl_j, ind_j;
    logic               chunk_is_last;

    assign in_accept  = s_valid && s_ready;
    assign out_accept = m_valid && m_ready;

    // Room for two results keeps the queue safe for any transaction.
    assign s_ready = (qcount_reg < QCNT_W'(QDEPTH - 1));
    assign m_valid = (qcount_reg != '0);

    assign m_result_kind   = queue_reg[rd_ptr_reg].kind;
    assign m_sector_number = queue_reg[rd_ptr_reg].sector;
    assign m_sector_offset = queue_reg[rd_ptr_reg].sofs;
    assign m_chunk_length  = queue_reg[rd_ptr_reg].len;
    assign m_bytes_done    = queue_reg[rd_ptr_reg].done;
    assign m_last          = queue_reg[rd_ptr_reg].last;

    // First chunk of a new request: least of count, file bytes left and sector bytes left.
    always_comb begin
        req_file_left = (s_file_length > s_start_offset) ? (s_file_length - s_start_offset)
                                                         : '0;
        req_sec_left  = CHUNK_W'(SECTOR_BYTES) - CHUNK_W'(s_start_offset[SECTOR_LOG2-1:0]);
        req_min       = (s_byte_count < req_file_left) ? s_byte_count : req_file_left;
        req_chunk     = (req_min < OFS_W'(req_sec_left)) ? CHUNK_W'(req_min) : req_sec_left;
        req_idx       = IDX_W'(s_start_offset >> SECTOR_LOG2);
    end

    // After a chunk that fills its sector the next one starts on a sector boundary,
    // so its length is bounded by a whole sector and its index is one higher.
    always_comb begin
        cnt_after     = count_reg - OFS_W'(chunk_reg);
        fl_after      = file_left_reg - OFS_W'(chunk_reg);
        min_after     = (cnt_after < fl_after) ? cnt_after : fl_after;
        next_chunk    = (min_after < OFS_W'(SECTOR_BYTES)) ? CHUNK_W'(min_after)
                                                           : CHUNK_W'(SECTOR_BYTES);
        chunk_is_last = (cnt_after == '0) || (fl_after == '0);
        idx_inc       = idx_reg + IDX_W'(1);
        dbl_j         = ((idx_reg - BEYOND_IDX) >> EPB_LOG2) & IDX_W'(ENTRIES_PER_BLOCK - 1);
        ind_j         = (idx_reg < BEYOND_IDX) ? (idx_reg - DIRECT_IDX)
                                               : ((idx_reg - BEYOND_IDX)
                                                  & IDX_W'(ENTRIES_PER_BLOCK - 1));
    end

    // Next walk state and the results of the accepted transaction.
    always_comb begin
        active_next    = active_reg;
        level_next     = level_reg;
        home_next      = home_reg;
        cursor_next    = cursor_reg;
        count_next     = count_reg;
        file_left_next = file_left_reg;
        done_next      = done_reg;
        idx_next       = idx_reg;
        chunk_next     = chunk_reg;
        push_cnt       = 2'd0;
        res0           = '0;
        res1           = '0;

        if (in_accept) begin
            if (s_operation == OP_REQUEST) begin
                // A request while a walk is in progress is dropped.
                if (!active_reg) begin
                    home_next      = s_inode_sector;
                    cursor_next    = s_start_offset;
                    count_next     = s_byte_count;
                    file_left_next = req_file_left;
                    done_next      = '0;
                    chunk_next     = req_chunk;
                    push_cnt       = 2'd1;
                    if (req_chunk == '0) begin
                        res0.kind = KIND_EMPTY;
                        res0.last = 1'b1;
                    end else begin
                        res0        = begin_read(s_inode_sector, req_idx);
                        level_next  = level_of(req_idx);
                        idx_next    = req_idx;
                        active_next = 1'b1;
                    end
                end
            end else if (active_reg) begin
                unique case (level_reg)
                    LVL_DBL: begin
                        res0.kind   = KIND_PTR_READ;
                        res0.sector = s_read_word;
                        res0.sofs   = entry_offset(dbl_j);
                        level_next  = LVL_IND;
                        push_cnt    = 2'd1;
                    end
                    LVL_IND: begin
                        res0.kind   = KIND_PTR_READ;
                        res0.sector = s_read_word;
                        res0.sofs   = entry_offset(ind_j);
                        level_next  = LVL_DATA;
                        push_cnt    = 2'd1;
                    end
                    LVL_DATA: begin
                        res0.kind      = KIND_CHUNK;
                        res0.sector    = s_read_word;
                        res0.sofs      = SOFS_W'(cursor_reg[SECTOR_LOG2-1:0]);
                        res0.len       = LEN_W'(chunk_reg);
                        res0.done      = done_reg;
                        res0.last      = chunk_is_last;
                        count_next     = cnt_after;
                        file_left_next = fl_after;
                        cursor_next    = cursor_reg + OFS_W'(chunk_reg);
                        done_next      = done_reg + OFS_W'(chunk_reg);
                        chunk_next     = next_chunk;
                        if (chunk_is_last) begin
                            active_next = 1'b0;
                            level_next  = LVL_NONE;
                            push_cnt    = 2'd1;
                        end else begin
                            res1       = begin_read(home_reg, idx_inc);
                            level_next = level_of(idx_inc);
                            idx_next   = idx_inc;
                            push_cnt   = 2'd2;
                        end
                    end
                    default: begin
                        // No word awaited: the response is dropped.
                        push_cnt = 2'd0;
                    end
                endcase
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            level_reg  <= LVL_NONE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            qcount_reg <= '0;
        end else begin
            active_reg <= active_next;
            level_reg  <= level_next;
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_cnt);
            if (out_accept) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            qcount_reg <= qcount_reg + QCNT_W'(push_cnt) - QCNT_W'(out_accept);
        end
    end

    // Walk payload registers.
    always_ff @(posedge aclk) begin
        home_reg      <= home_next;
        cursor_reg    <= cursor_next;
        count_reg     <= count_next;
        file_left_reg <= file_left_next;
        done_reg      <= done_next;
        idx_reg       <= idx_next;
        chunk_reg     <= chunk_next;
    end

    // Result queue storage: up to two entries written per transaction.
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2) begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for block_map_range_walker_core: directed rows, then
// random range requests and pointer responses checked against a predictor.
// Depends on bmrw_pkg and the walker RTL only.
module testbench
    import bmrw_pkg::*;
;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 900;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int BEYOND        = DIRECT_ENTRIES + ENTRIES_PER_BLOCK;
    localparam int MAP_SECTORS   = BEYOND + ENTRIES_PER_BLOCK * ENTRIES_PER_BLOCK;
    localparam int FILE_MAX      = MAP_SECTORS * SECTOR_BYTES;
    localparam int SHORT_SPAN    = 1500;

    // How a directed row is checked.
    typedef enum int {
        ROW_PREDICTED,
        ROW_SILENT,
        ROW_TYPED
    } row_check_t;

    // Stall patterns of the result receiver.
    typedef enum int {
        RX_STREAM,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    typedef struct {
        op_t              op;
        logic [SEC_W-1:0] inode;
        logic [OFS_W-1:0] offset;
        logic [OFS_W-1:0] count;
        logic [OFS_W-1:0] flen;
        logic [SEC_W-1:0] word;
        row_check_t       check;
        result_t          typed_res;
    } stim_row_t;

    typedef struct {
        result_t         res;
        longint unsigned stamp;
    } pending_t;

    localparam result_t NOTHING_TO_DO      = '{KIND_EMPTY, '0, '0, '0, '0, 1'b1};
    localparam result_t FIRST_DIRECT_READ  = '{KIND_PTR_READ, 32'hFFFF_FFFF, 9'd8, '0, '0, 1'b0};
    localparam result_t ONE_BYTE_CHUNK     = '{KIND_CHUNK, 32'hFFFF_FFFF, 9'd0, 10'd1, '0, 1'b1};
    localparam result_t INDIRECT_SLOT_READ = '{KIND_PTR_READ, 32'h0000_1234, 9'd500, '0, '0, 1'b0};

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic              s_operation    = 1'b0;
    logic [SEC_W-1:0]  s_inode_sector = '0;
    logic [OFS_W-1:0]  s_start_offset = '0;
    logic [OFS_W-1:0]  s_byte_count   = '0;
    logic [OFS_W-1:0]  s_file_length  = '0;
    logic [SEC_W-1:0]  s_read_word    = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [1:0]        m_result_kind;
    logic [SEC_W-1:0]  m_sector_number;
    logic [SOFS_W-1:0] m_sector_offset;
    logic [LEN_W-1:0]  m_chunk_length;
    logic [OFS_W-1:0]  m_bytes_done;
    logic              m_last;

    block_map_range_walker_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_inode_sector  (s_inode_sector),
        .s_start_offset  (s_start_offset),
        .s_byte_count    (s_byte_count),
        .s_file_length   (s_file_length),
        .s_read_word     (s_read_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_sector_number (m_sector_number),
        .m_sector_offset (m_sector_offset),
        .m_chunk_length  (m_chunk_length),
        .m_bytes_done    (m_bytes_done),
        .m_last          (m_last)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Walk state as the block should hold it.
    bit               walking    = 1'b0;
    level_t           wait_level = LVL_NONE;
    logic [SEC_W-1:0] home       = '0;
    logic [OFS_W-1:0] cursor     = '0;
    logic [OFS_W-1:0] remaining  = '0;
    logic [OFS_W-1:0] flen_held  = '0;
    logic [OFS_W-1:0] done_bytes = '0;
    logic [IDX_W-1:0] chunk_index = '0;

    result_t  step_out[$];
    pending_t pending_q[$];

    int mismatches       = 0;
    int results_seen     = 0;
    int n_ranges         = 0;
    int n_empty          = 0;
    int n_busy_requests  = 0;
    int n_responses      = 0;
    int n_idle_responses = 0;
    int n_chunks         = 0;
    int n_ptr_reads      = 0;
    int burst_left       = 1;
    int idle_cycles      = 0;
    int ready_left       = 0;
    rx_mode_t ready_mode = RX_STREAM;

    function automatic void emit(result_kind_t kind, logic [SEC_W-1:0] sector,
                                 int unsigned sofs, int unsigned len, int unsigned pos,
                                 logic lst);
        result_t r;
        r.kind   = kind;
        r.sector = sector;
        r.sofs   = SOFS_W'(sofs);
        r.len    = LEN_W'(len);
        r.done   = OFS_W'(pos);
        r.last   = lst;
        step_out.push_back(r);
        if (kind == KIND_CHUNK) n_chunks++;
        if (kind == KIND_PTR_READ) n_ptr_reads++;
    endfunction

    // Bytes in the chunk at the cursor: bounded by the count, the file and the sector.
    function automatic int unsigned chunk_bytes();
        int unsigned file_left;
        int unsigned sec_left;
        int unsigned c;
        file_left = (flen_held > cursor) ? flen_held - cursor : 0;
        sec_left  = SECTOR_BYTES - cursor % SECTOR_BYTES;
        c = remaining;
        if (file_left < c) c = file_left;
        if (sec_left < c) c = sec_left;
        return c;
    endfunction

    // First pointer read of the chunk at the cursor, always from the inode sector.
    function automatic void start_chunk();
        int unsigned ix;
        chunk_index = IDX_W'(cursor / SECTOR_BYTES);
        ix = chunk_index;
        if (ix < DIRECT_ENTRIES) begin
            emit(KIND_PTR_READ, home, DIRECT_BASE + ix * WORD_BYTES, 0, 0, 1'b0);
            wait_level = LVL_DATA;
        end else if (ix < BEYOND) begin
            emit(KIND_PTR_READ, home, SECTOR_BYTES - INDIRECT_SLOT, 0, 0, 1'b0);
            wait_level = LVL_IND;
        end else begin
            emit(KIND_PTR_READ, home, SECTOR_BYTES - DOUBLY_SLOT, 0, 0, 1'b0);
            wait_level = LVL_DBL;
        end
        walking = 1'b1;
    endfunction

    // Expected results of one accepted transaction, left in step_out.
    function automatic void map_walk_step(stim_row_t r);
        int unsigned ix;
        int unsigned j;
        int unsigned len;
        int unsigned sofs;
        int unsigned pos;
        step_out.delete();
        ix = chunk_index;
        if (r.op == OP_REQUEST) begin
            if (walking) begin
                n_busy_requests++;
                return;
            end
            n_ranges++;
            home       = r.inode;
            cursor     = r.offset;
            remaining  = r.count;
            flen_held  = r.flen;
            done_bytes = '0;
            if (chunk_bytes() == 0) begin
                emit(KIND_EMPTY, '0, 0, 0, 0, 1'b1);
                n_empty++;
            end else begin
                start_chunk();
            end
            return;
        end
        if (!walking) begin
            n_idle_responses++;
            return;
        end
        n_responses++;
        case (wait_level)
            LVL_DBL: begin
                // Index into the doubly indirect block wraps at the block size.
                j = ((ix - BEYOND) / ENTRIES_PER_BLOCK) % ENTRIES_PER_BLOCK;
                emit(KIND_PTR_READ, r.word, j * WORD_BYTES, 0, 0, 1'b0);
                wait_level = LVL_IND;
            end
            LVL_IND: begin
                j = (ix < BEYOND) ? ix - DIRECT_ENTRIES : (ix - BEYOND) % ENTRIES_PER_BLOCK;
                emit(KIND_PTR_READ, r.word, j * WORD_BYTES, 0, 0, 1'b0);
                wait_level = LVL_DATA;
            end
            default: begin
                // Data sector known: emit the chunk, then open the next one if any.
                len        = chunk_bytes();
                sofs       = cursor % SECTOR_BYTES;
                pos        = done_bytes;
                remaining  = remaining - OFS_W'(len);
                cursor     = cursor + OFS_W'(len);
                done_bytes = done_bytes + OFS_W'(len);
                if (chunk_bytes() == 0) begin
                    emit(KIND_CHUNK, r.word, sofs, len, pos, 1'b1);
                    walking    = 1'b0;
                    wait_level = LVL_NONE;
                end else begin
                    emit(KIND_CHUNK, r.word, sofs, len, pos, 1'b0);
                    start_chunk();
                end
            end
        endcase
    endfunction

    function automatic stim_row_t req(int unsigned inode, int unsigned offset,
                                      int unsigned count, int unsigned flen);
        stim_row_t r;
        r.op        = OP_REQUEST;
        r.inode     = inode;
        r.offset    = OFS_W'(offset);
        r.count     = OFS_W'(count);
        r.flen      = OFS_W'(flen);
        r.word      = $urandom;
        r.check     = ROW_PREDICTED;
        r.typed_res = '0;
        return r;
    endfunction

    function automatic stim_row_t rsp(int unsigned word);
        stim_row_t r;
        r       = req($urandom, $urandom, $urandom, $urandom_range(0, FILE_MAX));
        r.op    = OP_RESPONSE;
        r.word  = word;
        return r;
    endfunction

    function automatic stim_row_t with_result(stim_row_t r, result_t e);
        r.check     = ROW_TYPED;
        r.typed_res = e;
        return r;
    endfunction

    function automatic stim_row_t no_result(stim_row_t r);
        r.check = ROW_SILENT;
        return r;
    endfunction

    // Random transaction: mostly what the walk state accepts, with some noise.
    function automatic stim_row_t next_random_row();
        bit          want_request;
        int unsigned sel;
        int unsigned fl;
        int unsigned ofs;
        int unsigned cnt;
        int unsigned idx;
        want_request = walking ? ($urandom_range(0, 11) == 0) : ($urandom_range(0, 11) != 0);
        if (!want_request) begin
            sel = $urandom_range(0, 9);
            return rsp(sel == 0 ? 32'd0 : (sel == 1 ? 32'hFFFF_FFFF : $urandom));
        end
        sel = $urandom_range(0, 3);
        fl  = (sel == 0) ? FILE_MAX :
              (sel == 1) ? $urandom_range(0, 4096) : $urandom_range(0, FILE_MAX);
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            ofs = $urandom_range(0, 24'hFF_FFFF);
        end else if (sel <= 2) begin
            // Land near the edges of the direct, indirect and doubly indirect map.
            case ($urandom_range(0, 4))
                0:       idx = DIRECT_ENTRIES - 1;
                1:       idx = DIRECT_ENTRIES;
                2:       idx = BEYOND - 1;
                3:       idx = BEYOND;
                default: idx = MAP_SECTORS - 1;
            endcase
            ofs = idx * SECTOR_BYTES + $urandom_range(0, SECTOR_BYTES - 1);
            if ($urandom_range(0, 3) != 0) fl = FILE_MAX;
        end else begin
            ofs = (fl > 0) ? $urandom_range(0, fl - 1) : 0;
        end
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            cnt = 0;
        end else if (sel <= 2) begin
            // Long counts only near the end of the file, so the walk stays short.
            cnt = (sel == 1) ? 24'hFF_FFFF : $urandom_range(0, 24'hFF_FFFF);
            if (fl > ofs && fl - ofs > SHORT_SPAN) ofs = fl - $urandom_range(1, SHORT_SPAN);
        end else begin
            cnt = $urandom_range(1, SHORT_SPAN);
        end
        return req($urandom, ofs, cnt, fl);
    endfunction

    // Queue what an accepted transaction should produce.
    function automatic void log_accepted(stim_row_t r);
        pending_t p;
        map_walk_step(r);
        p.stamp = $time;
        if (r.check == ROW_TYPED) begin
            p.res = r.typed_res;
            pending_q.push_back(p);
        end else if (r.check == ROW_PREDICTED) begin
            foreach (step_out[i]) begin
                p.res = step_out[i];
                pending_q.push_back(p);
            end
        end
    endfunction

    // Offer one transaction, hold it until accepted, then maybe leave a gap.
    task automatic send_row(input stim_row_t r);
        s_valid        <= 1'b1;
        s_operation    <= r.op;
        s_inode_sector <= r.inode;
        s_start_offset <= r.offset;
        s_byte_count   <= r.count;
        s_file_length  <= r.flen;
        s_read_word    <= r.word;
        do @(posedge aclk); while (s_ready !== 1'b1);
        log_accepted(r);
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Stop sending until every expected result has been taken or the drain limit is reached.
    task automatic drain_results();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
            waited++;
        end while (pending_q.size() != 0 && waited < DRAIN_LIMIT);
    endtask

    function automatic void check_field(string name, logic [31:0] expected,
                                        logic [31:0] actual);
        if (actual !== expected) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
            mismatches++;
        end
    endfunction

    // Compare each result transaction with the oldest expectation from an earlier cycle.
    always @(posedge aclk) begin : check_results
        pending_t p;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0 || pending_q[0].stamp == $time) begin
                $error("Unexpected result transaction: kind %0d, sector 0x%0h",
                       m_result_kind, m_sector_number);
                mismatches++;
            end else begin
                p = pending_q.pop_front();
                results_seen++;
                check_field("result_kind", p.res.kind, m_result_kind);
                check_field("sector_number", p.res.sector, m_sector_number);
                check_field("sector_offset", p.res.sofs, m_sector_offset);
                check_field("chunk_length", p.res.len, m_chunk_length);
                check_field("bytes_done", p.res.done, m_bytes_done);
                check_field("last", p.res.last, m_last);
            end
        end
    end

    // The receiver stalls in stretches, each with a pattern of its own.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = rx_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(16, 96);
        end
        ready_left--;
        case (ready_mode)
            RX_STREAM: m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= (ready_left % 5 != 0);
        endcase
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("No transaction for %0d cycles", IDLE_LIMIT);
            $display("block_map_range_walker_core regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t r;
        int        effective;
        bit        paused;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle and empty cases, then a one-byte direct read with a request while busy.
        rows.push_back(no_result(rsp(32'h0000_0001)));
        rows.push_back(with_result(req(32'd0, 0, 0, FILE_MAX), NOTHING_TO_DO));
        rows.push_back(with_result(req(32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, FILE_MAX),
                                   NOTHING_TO_DO));
        rows.push_back(with_result(req(32'h0000_0042, 1000, 5, 1000), NOTHING_TO_DO));
        rows.push_back(with_result(req(32'h0000_0043, 0, 100, 0), NOTHING_TO_DO));
        rows.push_back(with_result(req(32'hFFFF_FFFF, 0, 1, FILE_MAX), FIRST_DIRECT_READ));
        rows.push_back(no_result(req(32'h1234_5678, 0, 700, FILE_MAX)));
        rows.push_back(with_result(rsp(32'hFFFF_FFFF), ONE_BYTE_CHUNK));
        // Three direct chunks crossing two sector boundaries.
        rows.push_back(req(32'h0000_0005, 500, 600, FILE_MAX));
        rows.push_back(rsp(32'h0000_0064));
        rows.push_back(rsp(32'h0000_0000));
        rows.push_back(rsp(32'h0000_0007));
        // First sector behind the indirect block.
        rows.push_back(with_result(req(32'h0000_1234, DIRECT_ENTRIES * SECTOR_BYTES,
                                       SECTOR_BYTES, FILE_MAX), INDIRECT_SLOT_READ));
        rows.push_back(rsp(32'hA5A5_A5A5));
        rows.push_back(rsp(32'h5A5A_5A5A));
        // Last indirect byte, then the first doubly indirect one.
        rows.push_back(req(32'h0000_0007, BEYOND * SECTOR_BYTES - 1, 2, FILE_MAX));
        rows.push_back(rsp(32'h0000_1111));
        rows.push_back(rsp(32'h0000_2222));
        rows.push_back(rsp(32'h0000_3333));
        rows.push_back(rsp(32'h0000_4444));
        rows.push_back(rsp(32'h0000_5555));
        // Last byte of the largest file, with the count cut by the file length.
        rows.push_back(req(32'h8000_0000, FILE_MAX - 1, 24'hFF_FFFF, FILE_MAX));
        rows.push_back(rsp(32'hFFFF_0000));
        rows.push_back(rsp(32'h0000_FFFF));
        rows.push_back(rsp(32'hDEAD_BEEF));
        foreach (rows[i]) send_row(rows[i]);
        drain_results();

        // Random ranges; only transactions the walker acts on are counted.
        effective = 0;
        paused    = 1'b0;
        while (effective < RANDOM_ITEMS || walking) begin
            r = next_random_row();
            if ((r.op == OP_REQUEST) != walking) effective++;
            send_row(r);
            if (!paused && effective >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_q.size() != 0) begin
            $error("%0d expected results never arrived", pending_q.size());
            mismatches += pending_q.size();
        end

        $display("Walked %0d ranges (%0d empty) over %0d pointer responses: %0d chunks, %0d reads.",
                 n_ranges, n_empty, n_responses, n_chunks, n_ptr_reads);
        $display("%0d results checked; %0d busy requests and %0d idle responses ignored.",
                 results_seen, n_busy_requests, n_idle_responses);
        if (mismatches == 0) begin
            $display("block_map_range_walker_core regression: pass");
        end else begin
            $display("block_map_range_walker_core regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bmrw_pkg.sv
rtl/core/block_map_range_walker_core.sv
tb/sv/testbench.sv
